[sv/fpfa_pkg.sv]
// Shared types and codes for the fixed-partition fit allocator.
`timescale 1ns / 1ps

package fpfa_pkg;

	// Fixed widths of configuration and totals
	localparam int CNT_W = 7;
	localparam int TOT_W = 22;
	localparam int FIT_W = 2;
	localparam int CFG_DATA_W = 7;

	// Input actions
	typedef enum logic [1:0] {
		ACT_LOAD    = 2'd0,
		ACT_PLACE   = 2'd1,
		ACT_RESTART = 2'd2,
		ACT_NONE    = 2'd3
	} action_e;

	// Result status codes
	typedef enum logic [2:0] {
		STAT_PLACED    = 3'd0,
		STAT_NO_FIT    = 3'd1,
		STAT_LOADED    = 3'd2,
		STAT_RESTARTED = 3'd3,
		STAT_RANGE     = 3'd4
	} status_e;

	// Placement policies; the spare code acts as first fit
	typedef enum logic [1:0] {
		FIT_FIRST = 2'd0,
		FIT_BEST  = 2'd1,
		FIT_WORST = 2'd2
	} fit_e;

	// Configuration register indexes
	typedef enum logic {
		CFG_FIT_MODE   = 1'b0,
		CFG_PART_COUNT = 1'b1
	} cfg_idx_e;

	// Sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_e;

	// Broadcast commands from the sequencer to every cell
	typedef struct packed {
		logic ld;
		logic clr;
		logic mark;
	} cell_cmd_t;

	// Flags carried by the scan token
	typedef struct packed {
		logic place;
		logic found;
	} tok_flags_t;

endpackage

[sv/fpfa_cell.sv]
// One partition cell: holds a size and a used mark, updates the passing scan token.
`timescale 1ns / 1ps

module fpfa_cell #(
	parameter int MAX_PARTITIONS = 64,
	parameter int SIZE_BITS = 16,
	parameter int IDX = 0
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  fpfa_pkg::cell_cmd_t           cmd,
	input  logic [$clog2(MAX_PARTITIONS)-1:0] ld_idx,
	input  logic [SIZE_BITS-1:0]          ld_size,
	input  logic [$clog2(MAX_PARTITIONS)-1:0] mark_idx,
	input  logic [fpfa_pkg::FIT_W-1:0]    fit_mode,
	input  logic [fpfa_pkg::CNT_W-1:0]    part_count,
	input  fpfa_pkg::tok_flags_t          tin_flags,
	input  logic [SIZE_BITS-1:0]          tin_req,
	input  logic [$clog2(MAX_PARTITIONS)-1:0] tin_idx,
	input  logic [SIZE_BITS-1:0]          tin_size,
	input  logic [fpfa_pkg::TOT_W-1:0]    tin_acc,
	output fpfa_pkg::tok_flags_t          tout_flags,
	output logic [SIZE_BITS-1:0]          tout_req,
	output logic [$clog2(MAX_PARTITIONS)-1:0] tout_idx,
	output logic [SIZE_BITS-1:0]          tout_size,
	output logic [fpfa_pkg::TOT_W-1:0]    tout_acc
);

	localparam int IDX_W = $clog2(MAX_PARTITIONS);
	localparam int EW = (IDX_W + 1 > fpfa_pkg::CNT_W) ? IDX_W + 1 : fpfa_pkg::CNT_W;
	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

	logic [SIZE_BITS-1:0] size_q;
	logic                 used_q;
	logic                 active;
	logic                 avail;
	logic                 fits;
	logic                 better;
	logic                 take;

	// Partition size, written by a load
	always_ff @(posedge clk) begin
		if (cmd.ld && ld_idx == MY_IDX) begin
			size_q <= ld_size;
		end
	end

	// Used mark: set at reset and on placement, cleared by restart
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= 1'b1;
		end else if (cmd.clr) begin
			used_q <= 1'b0;
		end else if (cmd.mark && mark_idx == MY_IDX) begin
			used_q <= 1'b1;
		end
	end

	// Candidate test against the token
	always_comb begin
		active = EW'(IDX) < EW'(part_count);
		avail  = active && !used_q;
		fits   = avail && (size_q >= tin_req);
		case (fit_mode)
			fpfa_pkg::FIT_BEST:  better = size_q < tin_size;
			fpfa_pkg::FIT_WORST: better = size_q > tin_size;
			default:             better = 1'b0;
		endcase
		take = tin_flags.place && fits && (!tin_flags.found || better);
	end

	// Token register handed to the next cell
	always_ff @(posedge clk) begin
		tout_flags.place <= tin_flags.place;
		tout_flags.found <= tin_flags.found || take;
		tout_req         <= tin_req;
		tout_idx         <= take ? MY_IDX : tin_idx;
		tout_size        <= take ? size_q : tin_size;
		tout_acc         <= tin_acc + (avail ? fpfa_pkg::TOT_W'(size_q) : '0);
	end

endmodule

[sv/fixed_partition_fit_allocator.sv]
// Top level of the fixed-partition fit allocator: sequencer, totals and cell chain.
`timescale 1ns / 1ps

// Usage:
// Input channel (in_valid/in_ready) takes one word: action, entry_index, size_value.
// Output channel (out_valid/out_ready) gives one word per input word: status,
// chosen_index, chosen_size, internal_total, free_total.
// Config channel (cfg_valid/cfg_ready, always ready) writes fit_mode (index 0)
// or partition_count (index 1); write it only while the block is idle.
// Every word runs a token down the row of MAX_PARTITIONS cells, one cell per
// cycle, to pick a partition and add up the free space. The next word is
// taken only in idle, once the finish step has loaded the result.
// The result sits in an output register; a new word is accepted while it waits,
// but that word's result holds in the finish step until out_ready frees the
// register.
// Reset marks every partition used, clears the internal fragmentation total and
// sets both config registers to zero. Sizes are undefined until loaded.

module fixed_partition_fit_allocator #(
	parameter int MAX_PARTITIONS = 64,
	parameter int SIZE_BITS = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [1:0]                            action,
	input  logic [$clog2(MAX_PARTITIONS)-1:0]     entry_index,
	input  logic [SIZE_BITS-1:0]                  size_value,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [2:0]                            status,
	output logic [$clog2(MAX_PARTITIONS)-1:0]     chosen_index,
	output logic [SIZE_BITS-1:0]                  chosen_size,
	output logic [fpfa_pkg::TOT_W-1:0]            internal_total,
	output logic [fpfa_pkg::TOT_W-1:0]            free_total,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic                                  cfg_index,
	input  logic [fpfa_pkg::CFG_DATA_W-1:0]       cfg_data
);

	localparam int IDX_W = $clog2(MAX_PARTITIONS);
	localparam int EW = (IDX_W + 1 > fpfa_pkg::CNT_W) ? IDX_W + 1 : fpfa_pkg::CNT_W;
	localparam logic [IDX_W-1:0] LAST_CNT = IDX_W'(MAX_PARTITIONS - 1);

	fpfa_pkg::state_e              state_q, state_d;
	logic [IDX_W-1:0]              cnt_q;
	logic [fpfa_pkg::FIT_W-1:0]    fit_mode_q;
	logic [fpfa_pkg::CNT_W-1:0]    count_q;
	logic [SIZE_BITS-1:0]          req_q;
	logic                          place_q;
	logic [2:0]                    st_q;
	logic [fpfa_pkg::TOT_W-1:0]    internal_q;

	logic                          out_vld_q;
	logic [2:0]                    status_q;
	logic [IDX_W-1:0]              cidx_q;
	logic [SIZE_BITS-1:0]          csize_q;
	logic [fpfa_pkg::TOT_W-1:0]    itot_q;
	logic [fpfa_pkg::TOT_W-1:0]    ftot_q;

	logic                          in_acc;
	logic                          in_range;
	logic                          fin_go;
	logic                          placed;
	logic [fpfa_pkg::TOT_W-1:0]    itot_next;
	logic [fpfa_pkg::TOT_W-1:0]    ftot_next;
	fpfa_pkg::cell_cmd_t           cmd;

	// Token chain, one slot per cell boundary
	fpfa_pkg::tok_flags_t          t_flags [MAX_PARTITIONS+1];
	logic [SIZE_BITS-1:0]          t_req   [MAX_PARTITIONS+1];
	logic [IDX_W-1:0]              t_idx   [MAX_PARTITIONS+1];
	logic [SIZE_BITS-1:0]          t_size  [MAX_PARTITIONS+1];
	logic [fpfa_pkg::TOT_W-1:0]    t_acc   [MAX_PARTITIONS+1];

	assign cfg_ready = 1'b1;
	assign in_acc    = in_valid && in_ready;
	assign in_range  = (EW'(entry_index) < EW'(count_q)) &&
	                   (EW'(entry_index) < EW'(MAX_PARTITIONS));

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_mode_q <= '0;
			count_q    <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				fpfa_pkg::CFG_FIT_MODE:   fit_mode_q <= cfg_data[fpfa_pkg::FIT_W-1:0];
				fpfa_pkg::CFG_PART_COUNT: count_q    <= cfg_data;
				default:                  count_q    <= count_q;
			endcase
		end
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fpfa_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and handshake
	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		fin_go   = 1'b0;
		unique case (state_q)
			fpfa_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = fpfa_pkg::ST_SCAN;
				end
			end
			fpfa_pkg::ST_SCAN: begin
				if (cnt_q == LAST_CNT) begin
					state_d = fpfa_pkg::ST_FINISH;
				end
			end
			fpfa_pkg::ST_FINISH: begin
				fin_go = !out_vld_q || out_ready;
				if (fin_go) begin
					state_d = fpfa_pkg::ST_IDLE;
				end
			end
			default: state_d = fpfa_pkg::ST_IDLE;
		endcase
	end

	// Scan cycle counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (in_acc) begin
			cnt_q <= '0;
		end else if (state_q == fpfa_pkg::ST_SCAN) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	// Word capture; status for everything but a placement is known here
	always_ff @(posedge clk) begin
		if (in_acc) begin
			req_q   <= size_value;
			place_q <= action == fpfa_pkg::ACT_PLACE;
			case (action)
				fpfa_pkg::ACT_LOAD:    st_q <= in_range ? fpfa_pkg::STAT_LOADED
				                                        : fpfa_pkg::STAT_RANGE;
				fpfa_pkg::ACT_RESTART: st_q <= fpfa_pkg::STAT_RESTARTED;
				default:               st_q <= fpfa_pkg::STAT_RANGE;
			endcase
		end
	end

	// Cell commands
	always_comb begin
		cmd.ld   = in_acc && action == fpfa_pkg::ACT_LOAD && in_range;
		cmd.clr  = in_acc && action == fpfa_pkg::ACT_RESTART;
		cmd.mark = fin_go && placed;
	end

	// Token entering the first cell
	always_comb begin
		t_flags[0].place = place_q;
		t_flags[0].found = 1'b0;
		t_req[0]         = req_q;
		t_idx[0]         = '0;
		t_size[0]        = '0;
		t_acc[0]         = '0;
	end

	// Row of cells
	for (genvar i = 0; i < MAX_PARTITIONS; i++) begin : g_cell
		fpfa_cell #(
			.MAX_PARTITIONS (MAX_PARTITIONS),
			.SIZE_BITS      (SIZE_BITS),
			.IDX            (i)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (cmd),
			.ld_idx     (entry_index),
			.ld_size    (size_value),
			.mark_idx   (t_idx[MAX_PARTITIONS]),
			.fit_mode   (fit_mode_q),
			.part_count (count_q),
			.tin_flags  (t_flags[i]),
			.tin_req    (t_req[i]),
			.tin_idx    (t_idx[i]),
			.tin_size   (t_size[i]),
			.tin_acc    (t_acc[i]),
			.tout_flags (t_flags[i+1]),
			.tout_req   (t_req[i+1]),
			.tout_idx   (t_idx[i+1]),
			.tout_size  (t_size[i+1]),
			.tout_acc   (t_acc[i+1])
		);
	end

	// Finish: totals from the token leaving the last cell
	always_comb begin
		placed    = place_q && t_flags[MAX_PARTITIONS].found;
		itot_next = internal_q;
		ftot_next = t_acc[MAX_PARTITIONS];
		if (placed) begin
			itot_next = internal_q +
			            fpfa_pkg::TOT_W'(t_size[MAX_PARTITIONS] - req_q);
			ftot_next = t_acc[MAX_PARTITIONS] -
			            fpfa_pkg::TOT_W'(t_size[MAX_PARTITIONS]);
		end
	end

	// Internal fragmentation total
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			internal_q <= '0;
		end else if (cmd.clr) begin
			internal_q <= '0;
		end else if (fin_go) begin
			internal_q <= itot_next;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (fin_go) begin
			out_vld_q <= 1'b1;
		end else if (out_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_go) begin
			if (place_q) begin
				status_q <= placed ? fpfa_pkg::STAT_PLACED : fpfa_pkg::STAT_NO_FIT;
			end else begin
				status_q <= st_q;
			end
			cidx_q  <= placed ? t_idx[MAX_PARTITIONS] : '0;
			csize_q <= placed ? t_size[MAX_PARTITIONS] : '0;
			itot_q  <= itot_next;
			ftot_q  <= ftot_next;
		end
	end

	assign out_valid      = out_vld_q;
	assign status         = status_q;
	assign chosen_index   = cidx_q;
	assign chosen_size    = csize_q;
	assign internal_total = itot_q;
	assign free_total     = ftot_q;

`ifndef NO_ASSERTIONS
	// Scan leaves only toward finish
	a_scan_exit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == fpfa_pkg::ST_SCAN |=>
			(state_q == fpfa_pkg::ST_SCAN || state_q == fpfa_pkg::ST_FINISH))
		else $error("scan left to a wrong state");

	// A finished word shows up on the output
	a_finish_out: assert property (@(posedge clk) disable iff (!arst_n)
		fin_go |=> out_valid)
		else $error("finished word not presented");

	// A placed partition is never smaller than the request
	a_fit_size: assert property (@(posedge clk) disable iff (!arst_n)
		(fin_go && placed) |=> (chosen_size >= $past(req_q)))
		else $error("placed partition smaller than request");

	// No word is taken while the token is still travelling
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == fpfa_pkg::ST_SCAN) |-> !in_ready)
		else $error("word accepted during scan");
`endif

endmodule
